@@ rtl/core/atacc_pkg.sv @@
// ----------------------------------------------------------------------------
// ATA command checker package
// Shared types and constants for the command front end, queue and executor.
// ----------------------------------------------------------------------------
package atacc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   // Result codes
   localparam logic [1:0] ST_READY = 2'd0;
   localparam logic [1:0] ST_ERROR = 2'd1;
   localparam logic [1:0] ST_HANG  = 2'd2;

   localparam logic [1:0] ER_NONE  = 2'd0;
   localparam logic [1:0] ER_ABORT = 2'd1;
   localparam logic [1:0] ER_IDNF  = 2'd2;
   localparam logic [1:0] ER_ECC   = 2'd3;

   localparam logic [1:0] XFER_NONE  = 2'd0;
   localparam logic [1:0] XFER_READ  = 2'd1;
   localparam logic [1:0] XFER_WRITE = 2'd2;

   // Reset values of the mode words
   localparam logic [15:0] PIO_RESET   = 16'h0000;
   localparam logic [15:0] MWDMA_RESET = 16'h0407;
   localparam logic [15:0] UDMA_RESET  = 16'h003f;

   // Command class decided by the front end
   typedef enum logic [3:0] {
      CLS_READ,
      CLS_WRITE,
      CLS_VERIFY,
      CLS_VERIFY_EXT,
      CLS_SET_PIO,
      CLS_SET_MWDMA,
      CLS_SET_UDMA,
      CLS_WCACHE_ON,
      CLS_WCACHE_OFF,
      CLS_NOP,
      CLS_ABORT
   } cls_type;

   typedef struct packed {
      logic [47:0] capacity_sectors;
      logic [3:0]  sector_shift;
      logic        lba48_enable;
      logic [3:0]  inject_mask;
      logic [47:0] fault_start;
      logic [31:0] fault_length;
   } cfg_type;

   // Classified command word passed from front to back
   typedef struct packed {
      cls_type     cls;
      logic [3:0]  mode_nib;
      logic [47:0] loc;
      logic [30:0] bytes;
      logic        cnt_zero;
      logic        buf_over;
      logic [48:0] cap_sum;   // loc + count
      logic [48:0] cmd_last;  // loc + count - 1
      logic        cmd_wrap;  // range end wraps to all ones
   } item_type;

   // Clear the high byte, then set bit nib+8 when it fits in the word
   function automatic logic [15:0] set_mode_bit(input logic [15:0] word,
                                                input logic [3:0]  nib);
      logic [7:0] hi;
      hi = nib[3] ? 8'h00 : (8'h01 << nib[2:0]);
      return {hi, word[7:0]};
   endfunction

endpackage

@@ rtl/core/atacc_front.sv @@
// ----------------------------------------------------------------------------
// ATA command front end
// Accepts a task-file word, builds address and count, classifies the opcode
// and registers the result for the queue.
// ----------------------------------------------------------------------------
module atacc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  atacc_pkg::cfg_type    cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            command_code,
   input  logic [23:0]           lba_current,
   input  logic [23:0]           lba_previous,
   input  logic [7:0]            device_head,
   input  logic [7:0]            count_current,
   input  logic [7:0]            count_previous,
   input  logic [7:0]            feature_code,
   input  logic [31:0]           buffer_bytes,
   output logic                  out_valid,
   input  logic                  out_ready,
   output atacc_pkg::item_type   out_item
);

   localparam logic [7:0] OP_READ_DMA      = 8'hc8;
   localparam logic [7:0] OP_READ_DMA_EXT  = 8'h25;
   localparam logic [7:0] OP_WRITE_DMA     = 8'hca;
   localparam logic [7:0] OP_WRITE_DMA_EXT = 8'h35;
   localparam logic [7:0] OP_VERIFY        = 8'h40;
   localparam logic [7:0] OP_VERIFY_EXT    = 8'h42;
   localparam logic [7:0] OP_SET_FEATURES  = 8'hef;
   localparam logic [7:0] OP_SET_MULT      = 8'hc6;
   localparam logic [7:0] OP_CHECK_POWER   = 8'he5;
   localparam logic [7:0] OP_STANDBY       = 8'he2;
   localparam logic [7:0] OP_IDENTIFY      = 8'hec;
   localparam logic [7:0] OP_PIDENTIFY     = 8'ha1;
   localparam logic [7:0] OP_FLUSH         = 8'he7;
   localparam logic [7:0] OP_FLUSH_EXT     = 8'hea;

   localparam logic [7:0] FEAT_XFER       = 8'h03;
   localparam logic [7:0] FEAT_WCACHE_ON  = 8'h02;
   localparam logic [7:0] FEAT_WCACHE_OFF = 8'h82;

   localparam logic [3:0] MODE_PIO   = 4'h0;
   localparam logic [3:0] MODE_MWDMA = 4'h2;
   localparam logic [3:0] MODE_UDMA  = 4'h4;

   logic                 valid_ff, valid_in;
   atacc_pkg::item_type  item_ff, item_in;
   logic                 accept;
   logic [47:0]          loc;
   logic [15:0]          cnt;
   logic [48:0]          sum;
   atacc_pkg::cls_type   cls;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      if (cfg.lba48_enable) begin
         loc = {lba_previous, lba_current};
         cnt = {count_previous, count_current};
      end else begin
         loc = {16'h0000, device_head, lba_current};
         cnt = {8'h00, count_current};
      end
      sum = {1'b0, loc} + 49'(cnt);
   end

   always_comb begin
      case (command_code)
         OP_READ_DMA:      cls = atacc_pkg::CLS_READ;
         OP_READ_DMA_EXT:  cls = cfg.lba48_enable ? atacc_pkg::CLS_READ
                                                  : atacc_pkg::CLS_ABORT;
         OP_WRITE_DMA:     cls = atacc_pkg::CLS_WRITE;
         OP_WRITE_DMA_EXT: cls = cfg.lba48_enable ? atacc_pkg::CLS_WRITE
                                                  : atacc_pkg::CLS_ABORT;
         OP_VERIFY:        cls = atacc_pkg::CLS_VERIFY;
         OP_VERIFY_EXT:    cls = atacc_pkg::CLS_VERIFY_EXT;
         OP_SET_FEATURES: begin
            case (feature_code)
               FEAT_XFER: begin
                  case (count_current[7:4])
                     MODE_PIO:   cls = atacc_pkg::CLS_SET_PIO;
                     MODE_MWDMA: cls = atacc_pkg::CLS_SET_MWDMA;
                     MODE_UDMA:  cls = atacc_pkg::CLS_SET_UDMA;
                     default:    cls = atacc_pkg::CLS_ABORT;
                  endcase
               end
               FEAT_WCACHE_ON:  cls = atacc_pkg::CLS_WCACHE_ON;
               FEAT_WCACHE_OFF: cls = atacc_pkg::CLS_WCACHE_OFF;
               default:         cls = atacc_pkg::CLS_ABORT;
            endcase
         end
         OP_SET_MULT, OP_CHECK_POWER, OP_STANDBY, OP_IDENTIFY,
         OP_PIDENTIFY, OP_FLUSH, OP_FLUSH_EXT: cls = atacc_pkg::CLS_NOP;
         default:          cls = atacc_pkg::CLS_ABORT;
      endcase
   end

   always_comb begin
      item_in.cls      = cls;
      item_in.mode_nib = count_current[3:0];
      item_in.loc      = loc;
      item_in.bytes    = 31'(cnt) << cfg.sector_shift;
      item_in.cnt_zero = (cnt == 16'h0000);
      item_in.buf_over = ({1'b0, item_in.bytes} > buffer_bytes);
      item_in.cap_sum  = sum;
      item_in.cmd_last = sum - 49'd1;
      item_in.cmd_wrap = (sum == 49'd0);
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the word until the queue takes it
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ rtl/core/atacc_queue.sv @@
// ----------------------------------------------------------------------------
// ATA command queue
// Small FIFO of classified commands between front end and executor.
// ----------------------------------------------------------------------------
module atacc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  atacc_pkg::item_type  in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output atacc_pkg::item_type  out_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   atacc_pkg::item_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

@@ rtl/core/atacc_back.sv @@
// ----------------------------------------------------------------------------
// ATA command executor
// Runs bound, buffer and fault-window checks, applies SET FEATURES and
// registers one result word per command.
// ----------------------------------------------------------------------------
module atacc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  atacc_pkg::cfg_type   cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  atacc_pkg::item_type  in_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status_code,
   output logic [1:0]           rsp_error_code,
   output logic [1:0]           rsp_transfer_kind,
   output logic [47:0]          rsp_transfer_sector,
   output logic [30:0]          rsp_transfer_bytes,
   output logic [47:0]          rsp_report_lba,
   output logic [15:0]          rsp_pio_word,
   output logic [15:0]          rsp_mwdma_word,
   output logic [15:0]          rsp_udma_word,
   output logic                 rsp_write_cache_on
);

   logic         valid_ff, valid_in;
   logic [1:0]   status_ff, status_in;
   logic [1:0]   error_ff, error_in;
   logic [1:0]   kind_ff, kind_in;
   logic [47:0]  sector_ff, sector_in;
   logic [30:0]  bytes_ff, bytes_in;
   logic [47:0]  report_ff, report_in;
   logic [15:0]  pio_ff, pio_in;
   logic [15:0]  mwdma_ff, mwdma_in;
   logic [15:0]  udma_ff, udma_in;
   logic         wcache_ff, wcache_in;
   logic [48:0]  fault_last_ff, fault_last_in;
   logic         fault_wrap_ff, fault_wrap_in;
   logic         pop, over_cap, hit, is_read, is_write;

   assign in_ready = !valid_ff || rsp_ready;
   assign pop      = in_valid && in_ready;

   // window end depends on configuration only; register it off the item path
   assign fault_last_in = {1'b0, cfg.fault_start} + 49'(cfg.fault_length) - 49'd1;
   assign fault_wrap_in = (cfg.fault_start == 48'd0) && (cfg.fault_length == 32'd0);

   always_comb begin
      over_cap = in_item.cap_sum > {1'b0, cfg.capacity_sectors};
      hit      = !(!in_item.cmd_wrap && (in_item.cmd_last < {1'b0, cfg.fault_start}))
                 && !(!fault_wrap_ff && (fault_last_ff < {1'b0, in_item.loc}));
      is_read  = (in_item.cls == atacc_pkg::CLS_READ);
      is_write = (in_item.cls == atacc_pkg::CLS_WRITE);
   end

   always_comb begin
      status_in = atacc_pkg::ST_READY;
      error_in  = atacc_pkg::ER_NONE;
      kind_in   = atacc_pkg::XFER_NONE;
      sector_in = '0;
      bytes_in  = '0;
      report_in = '0;
      pio_in    = pio_ff;
      mwdma_in  = mwdma_ff;
      udma_in   = udma_ff;
      wcache_in = wcache_ff;
      case (in_item.cls)
         atacc_pkg::CLS_READ, atacc_pkg::CLS_WRITE: begin
            if (over_cap) begin
               status_in = atacc_pkg::ST_ERROR;
               error_in  = atacc_pkg::ER_IDNF;
            end else if (in_item.buf_over) begin
               status_in = atacc_pkg::ST_ERROR;
               error_in  = atacc_pkg::ER_ABORT;
            end else if (is_read && cfg.inject_mask[0] && hit) begin
               status_in = atacc_pkg::ST_HANG;
            end else if (((is_read && cfg.inject_mask[1]) ||
                          (is_write && cfg.inject_mask[2])) && hit) begin
               status_in = atacc_pkg::ST_ERROR;
               error_in  = atacc_pkg::ER_ECC;
            end else if (!in_item.cnt_zero) begin
               kind_in   = is_read ? atacc_pkg::XFER_READ : atacc_pkg::XFER_WRITE;
               sector_in = in_item.loc;
               bytes_in  = in_item.bytes;
            end
         end
         atacc_pkg::CLS_VERIFY, atacc_pkg::CLS_VERIFY_EXT: begin
            if (over_cap) begin
               status_in = atacc_pkg::ST_ERROR;
               error_in  = atacc_pkg::ER_IDNF;
            end else if (cfg.inject_mask[3] && hit) begin
               status_in = atacc_pkg::ST_ERROR;
               error_in  = atacc_pkg::ER_ECC;
               // 28-bit verify reports only the low 32 address bits
               report_in = (in_item.cls == atacc_pkg::CLS_VERIFY)
                         ? {16'h0000, cfg.fault_start[31:0]} : cfg.fault_start;
            end
         end
         atacc_pkg::CLS_SET_PIO:
            pio_in = atacc_pkg::set_mode_bit(pio_ff, in_item.mode_nib);
         atacc_pkg::CLS_SET_MWDMA:
            mwdma_in = atacc_pkg::set_mode_bit(mwdma_ff, in_item.mode_nib);
         atacc_pkg::CLS_SET_UDMA:
            udma_in = atacc_pkg::set_mode_bit(udma_ff, in_item.mode_nib);
         atacc_pkg::CLS_WCACHE_ON:  wcache_in = 1'b1;
         atacc_pkg::CLS_WCACHE_OFF: wcache_in = 1'b0;
         atacc_pkg::CLS_NOP: ;
         default: begin
            status_in = atacc_pkg::ST_ERROR;
            error_in  = atacc_pkg::ER_ABORT;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         pio_ff    <= atacc_pkg::PIO_RESET;
         mwdma_ff  <= atacc_pkg::MWDMA_RESET;
         udma_ff   <= atacc_pkg::UDMA_RESET;
         wcache_ff <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            pio_ff    <= pio_in;
            mwdma_ff  <= mwdma_in;
            udma_ff   <= udma_in;
            wcache_ff <= wcache_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      fault_last_ff <= fault_last_in;
      fault_wrap_ff <= fault_wrap_in;
      if (pop) begin
         status_ff <= status_in;
         error_ff  <= error_in;
         kind_ff   <= kind_in;
         sector_ff <= sector_in;
         bytes_ff  <= bytes_in;
         report_ff <= report_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_status_code     = status_ff;
   assign rsp_error_code      = error_ff;
   assign rsp_transfer_kind   = kind_ff;
   assign rsp_transfer_sector = sector_ff;
   assign rsp_transfer_bytes  = bytes_ff;
   assign rsp_report_lba      = report_ff;
   // mode state only moves when a result is loaded, so it tracks the held word
   assign rsp_pio_word        = pio_ff;
   assign rsp_mwdma_word      = mwdma_ff;
   assign rsp_udma_word       = udma_ff;
   assign rsp_write_cache_on  = wcache_ff;

endmodule

@@ rtl/core/ata_command_checker.sv @@
// Throughput: one command per cycle; front register, queue and result
// register each pass one word a cycle and stall independently.
// Reset clears the queue and handshakes, restores the mode words to
// PIO 0x0000, MWDMA 0x0407, UDMA 0x003f, write cache on, and the defaults
// of the configuration registers.
// ----------------------------------------------------------------------------
// ATA command checker
// Validates task-file commands and reports status, error and transfer request.
// ----------------------------------------------------------------------------
module ata_command_checker #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [atacc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [atacc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_command_code,
   input  logic [23:0]                      req_lba_current,
   input  logic [23:0]                      req_lba_previous,
   input  logic [7:0]                       req_device_head,
   input  logic [7:0]                       req_count_current,
   input  logic [7:0]                       req_count_previous,
   input  logic [7:0]                       req_feature_code,
   input  logic [31:0]                      req_buffer_bytes,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status_code,
   output logic [1:0]                       rsp_error_code,
   output logic [1:0]                       rsp_transfer_kind,
   output logic [47:0]                      rsp_transfer_sector,
   output logic [30:0]                      rsp_transfer_bytes,
   output logic [47:0]                      rsp_report_lba,
   output logic [15:0]                      rsp_pio_word,
   output logic [15:0]                      rsp_mwdma_word,
   output logic [15:0]                      rsp_udma_word,
   output logic                             rsp_write_cache_on
);

   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] CSR_CAPACITY     = 3'd0;
   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] CSR_SECTOR_SHIFT = 3'd1;
   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] CSR_LBA48        = 3'd2;
   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] CSR_INJECT_MASK  = 3'd3;
   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] CSR_FAULT_START  = 3'd4;
   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] CSR_FAULT_LENGTH = 3'd5;

   atacc_pkg::cfg_type   cfg_ff, cfg_in;
   atacc_pkg::item_type  front_item, queue_item;
   logic                 front_valid, front_ready;
   logic                 queue_valid, queue_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_CAPACITY:     cfg_in.capacity_sectors = csr_wdata;
            CSR_SECTOR_SHIFT: cfg_in.sector_shift     = csr_wdata[3:0];
            CSR_LBA48:        cfg_in.lba48_enable     = csr_wdata[0];
            CSR_INJECT_MASK:  cfg_in.inject_mask      = csr_wdata[3:0];
            CSR_FAULT_START:  cfg_in.fault_start      = csr_wdata;
            CSR_FAULT_LENGTH: cfg_in.fault_length     = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity_sectors <= '0;
         cfg_ff.sector_shift     <= 4'd9;
         cfg_ff.lba48_enable     <= 1'b1;
         cfg_ff.inject_mask      <= '0;
         cfg_ff.fault_start      <= '0;
         cfg_ff.fault_length     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   atacc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .command_code   (req_command_code),
      .lba_current    (req_lba_current),
      .lba_previous   (req_lba_previous),
      .device_head    (req_device_head),
      .count_current  (req_count_current),
      .count_previous (req_count_previous),
      .feature_code   (req_feature_code),
      .buffer_bytes   (req_buffer_bytes),
      .out_valid      (front_valid),
      .out_ready      (front_ready),
      .out_item       (front_item)
   );

   atacc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   atacc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .in_valid            (queue_valid),
      .in_ready            (queue_ready),
      .in_item             (queue_item),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status_code     (rsp_status_code),
      .rsp_error_code      (rsp_error_code),
      .rsp_transfer_kind   (rsp_transfer_kind),
      .rsp_transfer_sector (rsp_transfer_sector),
      .rsp_transfer_bytes  (rsp_transfer_bytes),
      .rsp_report_lba      (rsp_report_lba),
      .rsp_pio_word        (rsp_pio_word),
      .rsp_mwdma_word      (rsp_mwdma_word),
      .rsp_udma_word       (rsp_udma_word),
      .rsp_write_cache_on  (rsp_write_cache_on)
   );

endmodule

@@ tb/tb_ata_command_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ATA command checker testbench
// Sends task-file commands through the request channel and checks every
// result word against a predictor kept in step with the register settings
// and the mode state. Directed commands come first, then random traffic under
// several register settings, with random idling, a long result hold-off and
// a drain pause.
// ----------------------------------------------------------------------------
module tb_ata_command_checker;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] REG_CAPACITY     = 3'd0;
   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] REG_SECTOR_SHIFT = 3'd1;
   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] REG_LBA48_ENABLE = 3'd2;
   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] REG_INJECT_MASK  = 3'd3;
   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] REG_FAULT_START  = 3'd4;
   localparam logic [atacc_pkg::CSR_INDEX_W-1:0] REG_FAULT_LENGTH = 3'd5;

   localparam logic [7:0] OP_READ_DMA      = 8'hC8;
   localparam logic [7:0] OP_READ_DMA_EXT  = 8'h25;
   localparam logic [7:0] OP_WRITE_DMA     = 8'hCA;
   localparam logic [7:0] OP_WRITE_DMA_EXT = 8'h35;
   localparam logic [7:0] OP_VERIFY        = 8'h40;
   localparam logic [7:0] OP_VERIFY_EXT    = 8'h42;
   localparam logic [7:0] OP_SET_FEATURES  = 8'hEF;
   localparam logic [7:0] OP_SET_MULT      = 8'hC6;
   localparam logic [7:0] OP_CHECK_POWER   = 8'hE5;
   localparam logic [7:0] OP_STANDBY       = 8'hE2;
   localparam logic [7:0] OP_IDENTIFY      = 8'hEC;
   localparam logic [7:0] OP_PIDENTIFY     = 8'hA1;
   localparam logic [7:0] OP_FLUSH         = 8'hE7;
   localparam logic [7:0] OP_FLUSH_EXT     = 8'hEA;
   localparam logic [7:0] OP_UNUSED        = 8'h00;

   localparam logic [7:0] FEAT_XFER_MODE   = 8'h03;
   localparam logic [7:0] FEAT_WCACHE_ON   = 8'h02;
   localparam logic [7:0] FEAT_WCACHE_OFF  = 8'h82;
   localparam logic [7:0] FEAT_UNUSED      = 8'h55;

   localparam logic [3:0] MODE_GRP_PIO     = 4'h0;
   localparam logic [3:0] MODE_GRP_MWDMA   = 4'h2;
   localparam logic [3:0] MODE_GRP_UDMA    = 4'h4;
   localparam logic [3:0] MODE_GRP_BAD     = 4'h6;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [23:0] lba_cur;
      logic [23:0] lba_prev;
      logic [7:0]  head;
      logic [7:0]  cnt_cur;
      logic [7:0]  cnt_prev;
      logic [7:0]  feature;
      logic [31:0] buffer;
   } ata_cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  error;
      logic [1:0]  kind;
      logic [47:0] sector;
      logic [30:0] nbytes;
      logic [47:0] report;
      logic [15:0] pio;
      logic [15:0] mwdma;
      logic [15:0] udma;
      logic        wcache;
   } ata_outcome_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_en;
   logic [atacc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [atacc_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                              req_valid;
   logic                              req_ready;
   logic [7:0]                        req_command_code;
   logic [23:0]                       req_lba_current;
   logic [23:0]                       req_lba_previous;
   logic [7:0]                        req_device_head;
   logic [7:0]                        req_count_current;
   logic [7:0]                        req_count_previous;
   logic [7:0]                        req_feature_code;
   logic [31:0]                       req_buffer_bytes;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [1:0]                        rsp_status_code;
   logic [1:0]                        rsp_error_code;
   logic [1:0]                        rsp_transfer_kind;
   logic [47:0]                       rsp_transfer_sector;
   logic [30:0]                       rsp_transfer_bytes;
   logic [47:0]                       rsp_report_lba;
   logic [15:0]                       rsp_pio_word;
   logic [15:0]                       rsp_mwdma_word;
   logic [15:0]                       rsp_udma_word;
   logic                              rsp_write_cache_on;

   // predictor copy of the registers and mode state
   atacc_pkg::cfg_type disk_cfg;
   logic [15:0]        pio_state;
   logic [15:0]        mwdma_state;
   logic [15:0]        udma_state;
   logic               wcache_state;

   ata_outcome_type pending_outcomes[$];

   bit sender_gaps     = 1'b1;
   bit receiver_stalls = 1'b1;
   int hold_request    = 0;
   int cycle_count     = 0;
   int fail_count      = 0;
   int cmds_sent       = 0;
   int outcomes_seen   = 0;
   int setting_count   = 0;

   ata_command_checker dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command_code    (req_command_code),
      .req_lba_current     (req_lba_current),
      .req_lba_previous    (req_lba_previous),
      .req_device_head     (req_device_head),
      .req_count_current   (req_count_current),
      .req_count_previous  (req_count_previous),
      .req_feature_code    (req_feature_code),
      .req_buffer_bytes    (req_buffer_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status_code     (rsp_status_code),
      .rsp_error_code      (rsp_error_code),
      .rsp_transfer_kind   (rsp_transfer_kind),
      .rsp_transfer_sector (rsp_transfer_sector),
      .rsp_transfer_bytes  (rsp_transfer_bytes),
      .rsp_report_lba      (rsp_report_lba),
      .rsp_pio_word        (rsp_pio_word),
      .rsp_mwdma_word      (rsp_mwdma_word),
      .rsp_udma_word       (rsp_udma_word),
      .rsp_write_cache_on  (rsp_write_cache_on)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_outcomes.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic atacc_pkg::cfg_type make_config(input logic [47:0] capacity,
                                                      input logic [3:0] shift,
                                                      input logic lba48,
                                                      input logic [3:0] mask,
                                                      input logic [47:0] fstart,
                                                      input logic [31:0] flength);
      atacc_pkg::cfg_type c;
      c.capacity_sectors = capacity;
      c.sector_shift     = shift;
      c.lba48_enable     = lba48;
      c.inject_mask      = mask;
      c.fault_start      = fstart;
      c.fault_length     = flength;
      return c;
   endfunction

   // ranges compare modulo 2^64, so a zero length at sector zero wraps the end to all ones
   function automatic bit window_overlaps(input logic [63:0] first, input logic [63:0] cnt);
      logic [63:0] cmd_end;
      logic [63:0] win_end;
      cmd_end = first + cnt - 64'd1;
      win_end = {16'd0, disk_cfg.fault_start} + {32'd0, disk_cfg.fault_length} - 64'd1;
      return !(cmd_end < {16'd0, disk_cfg.fault_start} || win_end < first);
   endfunction

   function automatic logic [15:0] select_mode(input logic [15:0] word, input logic [3:0] nib);
      logic [15:0] r;
      r = {8'h00, word[7:0]};
      if (nib < 4'd8)
         r[nib + 8] = 1'b1;
      return r;
   endfunction

   function automatic ata_outcome_type predict_outcome(input ata_cmd_type c);
      ata_outcome_type o;
      logic [63:0]     loc;
      logic [63:0]     cnt;
      logic [63:0]     nbytes;
      bit              is_read;
      bit              is_write;
      o = '0;
      o.status = atacc_pkg::ST_READY;
      o.error  = atacc_pkg::ER_NONE;
      o.kind   = atacc_pkg::XFER_NONE;
      is_read  = (c.opcode == OP_READ_DMA || c.opcode == OP_READ_DMA_EXT);
      is_write = (c.opcode == OP_WRITE_DMA || c.opcode == OP_WRITE_DMA_EXT);
      if (disk_cfg.lba48_enable) begin
         loc = {16'd0, c.lba_prev, c.lba_cur};
         cnt = {48'd0, c.cnt_prev, c.cnt_cur};
      end else begin
         loc = {32'd0, c.head, c.lba_cur};
         cnt = {56'd0, c.cnt_cur};
      end
      nbytes = cnt << disk_cfg.sector_shift;

      if (!disk_cfg.lba48_enable &&
          (c.opcode == OP_READ_DMA_EXT || c.opcode == OP_WRITE_DMA_EXT)) begin
         o.status = atacc_pkg::ST_ERROR;
         o.error  = atacc_pkg::ER_ABORT;
      end else if (is_read || is_write) begin
         if (loc + cnt > {16'd0, disk_cfg.capacity_sectors}) begin
            o.status = atacc_pkg::ST_ERROR;
            o.error  = atacc_pkg::ER_IDNF;
         end else if (nbytes > {32'd0, c.buffer}) begin
            o.status = atacc_pkg::ST_ERROR;
            o.error  = atacc_pkg::ER_ABORT;
         end else if (is_read && disk_cfg.inject_mask[0] && window_overlaps(loc, cnt)) begin
            o.status = atacc_pkg::ST_HANG;
         end else if (((is_read && disk_cfg.inject_mask[1]) ||
                       (is_write && disk_cfg.inject_mask[2])) && window_overlaps(loc, cnt)) begin
            o.status = atacc_pkg::ST_ERROR;
            o.error  = atacc_pkg::ER_ECC;
         end else if (cnt != 64'd0) begin
            o.kind   = is_read ? atacc_pkg::XFER_READ : atacc_pkg::XFER_WRITE;
            o.sector = loc[47:0];
            o.nbytes = nbytes[30:0];
         end
      end else if (c.opcode == OP_VERIFY || c.opcode == OP_VERIFY_EXT) begin
         if (loc + cnt > {16'd0, disk_cfg.capacity_sectors}) begin
            o.status = atacc_pkg::ST_ERROR;
            o.error  = atacc_pkg::ER_IDNF;
         end else if (disk_cfg.inject_mask[3] && window_overlaps(loc, cnt)) begin
            o.status = atacc_pkg::ST_ERROR;
            o.error  = atacc_pkg::ER_ECC;
            // plain VERIFY only reports the low 32 bits of the window start
            o.report = (c.opcode == OP_VERIFY) ? {16'd0, disk_cfg.fault_start[31:0]}
                                               : disk_cfg.fault_start;
         end
      end else if (c.opcode == OP_SET_FEATURES) begin
         if (c.feature == FEAT_XFER_MODE) begin
            case (c.cnt_cur[7:4])
               MODE_GRP_PIO:   pio_state   = select_mode(pio_state, c.cnt_cur[3:0]);
               MODE_GRP_MWDMA: mwdma_state = select_mode(mwdma_state, c.cnt_cur[3:0]);
               MODE_GRP_UDMA:  udma_state  = select_mode(udma_state, c.cnt_cur[3:0]);
               default: begin
                  o.status = atacc_pkg::ST_ERROR;
                  o.error  = atacc_pkg::ER_ABORT;
               end
            endcase
         end else if (c.feature == FEAT_WCACHE_ON) begin
            wcache_state = 1'b1;
         end else if (c.feature == FEAT_WCACHE_OFF) begin
            wcache_state = 1'b0;
         end else begin
            o.status = atacc_pkg::ST_ERROR;
            o.error  = atacc_pkg::ER_ABORT;
         end
      end else if (c.opcode == OP_SET_MULT || c.opcode == OP_CHECK_POWER ||
                   c.opcode == OP_STANDBY || c.opcode == OP_IDENTIFY ||
                   c.opcode == OP_PIDENTIFY || c.opcode == OP_FLUSH ||
                   c.opcode == OP_FLUSH_EXT) begin
         o.status = atacc_pkg::ST_READY;
      end else begin
         o.status = atacc_pkg::ST_ERROR;
         o.error  = atacc_pkg::ER_ABORT;
      end

      o.pio    = pio_state;
      o.mwdma  = mwdma_state;
      o.udma   = udma_state;
      o.wcache = wcache_state;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Command sources
   // ------------------------------------------------------------------
   function automatic ata_cmd_type make_cmd(input logic [7:0] op, input logic [47:0] loc,
                                            input logic [15:0] cnt, input logic [7:0] feat,
                                            input logic [31:0] buffer);
      ata_cmd_type c;
      c.opcode   = op;
      c.lba_cur  = loc[23:0];
      c.lba_prev = loc[47:24];
      c.head     = loc[31:24];
      c.cnt_cur  = cnt[7:0];
      c.cnt_prev = cnt[15:8];
      c.feature  = feat;
      c.buffer   = buffer;
      return c;
   endfunction

   function automatic ata_cmd_type random_command();
      ata_cmd_type c;
      logic [47:0] loc;
      logic [15:0] cnt;
      logic [63:0] nbytes;
      int          pick;
      c.opcode   = 8'($urandom);
      c.lba_cur  = 24'($urandom);
      c.lba_prev = 24'($urandom);
      c.head     = 8'($urandom);
      c.cnt_cur  = 8'($urandom);
      c.cnt_prev = 8'($urandom);
      c.feature  = 8'($urandom);
      c.buffer   = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         case ($urandom_range(0, 5))
            0: c.opcode = OP_READ_DMA;
            1: c.opcode = OP_READ_DMA_EXT;
            2: c.opcode = OP_WRITE_DMA;
            3: c.opcode = OP_WRITE_DMA_EXT;
            4: c.opcode = OP_VERIFY;
            default: c.opcode = OP_VERIFY_EXT;
         endcase
         case ($urandom_range(0, 4))
            0, 1, 2: cnt = 16'($urandom_range(0, 16));
            3:       cnt = 16'($urandom_range(0, 255));
            default: cnt = 16'($urandom);
         endcase
         if (!disk_cfg.lba48_enable)
            cnt[15:8] = 8'h00;
         // aim at the window edges and the capacity edge most of the time
         case ($urandom_range(0, 4))
            0: loc = disk_cfg.fault_start + 48'($urandom_range(0, 40)) - 48'd20;
            1: loc = disk_cfg.fault_start + 48'(disk_cfg.fault_length) - 48'(cnt)
                     + 48'($urandom_range(0, 4)) - 48'd2;
            2: loc = disk_cfg.capacity_sectors - 48'(cnt) - 48'($urandom_range(0, 2)) + 48'd1;
            3: loc = 48'($urandom_range(0, 1000));
            default: loc = {16'($urandom), $urandom};
         endcase
         c.lba_cur = loc[23:0];
         c.cnt_cur = cnt[7:0];
         if (disk_cfg.lba48_enable) begin
            c.lba_prev = loc[47:24];
            c.cnt_prev = cnt[15:8];
         end else begin
            c.head = loc[31:24];
         end
         nbytes = 64'(cnt) << disk_cfg.sector_shift;
         case ($urandom_range(0, 4))
            0, 1: c.buffer = nbytes[31:0];
            2:    c.buffer = nbytes[31:0] - 32'd1;
            3:    c.buffer = $urandom;
            default: c.buffer = 32'hFFFF_FFFF;
         endcase
      end else if (pick < 75) begin
         c.opcode = OP_SET_FEATURES;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: c.feature = FEAT_XFER_MODE;
            6: c.feature = FEAT_WCACHE_ON;
            7: c.feature = FEAT_WCACHE_OFF;
            default: c.feature = 8'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: c.cnt_cur[7:4] = MODE_GRP_PIO;
            1: c.cnt_cur[7:4] = MODE_GRP_MWDMA;
            2: c.cnt_cur[7:4] = MODE_GRP_UDMA;
            default: c.cnt_cur[7:4] = 4'($urandom);
         endcase
      end else if (pick < 88) begin
         case ($urandom_range(0, 6))
            0: c.opcode = OP_SET_MULT;
            1: c.opcode = OP_CHECK_POWER;
            2: c.opcode = OP_STANDBY;
            3: c.opcode = OP_IDENTIFY;
            4: c.opcode = OP_PIDENTIFY;
            5: c.opcode = OP_FLUSH;
            default: c.opcode = OP_FLUSH_EXT;
         endcase
      end
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers and result checker
   // ------------------------------------------------------------------
   task automatic send_command(input ata_cmd_type c);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command_code   <= c.opcode;
      req_lba_current    <= c.lba_cur;
      req_lba_previous   <= c.lba_prev;
      req_device_head    <= c.head;
      req_count_current  <= c.cnt_cur;
      req_count_previous <= c.cnt_prev;
      req_feature_code   <= c.feature;
      req_buffer_bytes   <= c.buffer;
      req_valid          <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_outcomes.push_back(predict_outcome(c));
      cmds_sent++;
   endtask

   // drop valid and wait out every outstanding result word
   task automatic drain_outcomes();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [atacc_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [atacc_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   task automatic apply_config(input atacc_pkg::cfg_type c);
      drain_outcomes();
      write_register(REG_CAPACITY, c.capacity_sectors);
      write_register(REG_SECTOR_SHIFT, 48'(c.sector_shift));
      write_register(REG_LBA48_ENABLE, 48'(c.lba48_enable));
      write_register(REG_INJECT_MASK, 48'(c.inject_mask));
      write_register(REG_FAULT_START, c.fault_start);
      write_register(REG_FAULT_LENGTH, 48'(c.fault_length));
      csr_write_en <= 1'b0;
      disk_cfg = c;
      setting_count++;
   endtask

   task automatic run_random_commands(input int count);
      repeat (count) send_command(random_command());
   endtask

   initial begin : rsp_pacing
      int stall;
      forever begin
         if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end
         stall = receiver_stalls ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic check_field(input string name, input logic [47:0] expected,
                              input logic [47:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_outcomes
      ata_outcome_type exp_o;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("result word with no command outstanding");
            fail_count++;
         end else begin
            exp_o = pending_outcomes.pop_front();
            outcomes_seen++;
            check_field("status_code", exp_o.status, rsp_status_code);
            check_field("error_code", exp_o.error, rsp_error_code);
            check_field("transfer_kind", exp_o.kind, rsp_transfer_kind);
            check_field("transfer_sector", exp_o.sector, rsp_transfer_sector);
            check_field("transfer_bytes", exp_o.nbytes, rsp_transfer_bytes);
            check_field("report_lba", exp_o.report, rsp_report_lba);
            check_field("pio_word", exp_o.pio, rsp_pio_word);
            check_field("mwdma_word", exp_o.mwdma, rsp_mwdma_word);
            check_field("udma_word", exp_o.udma, rsp_udma_word);
            check_field("write_cache_on", exp_o.wcache, rsp_write_cache_on);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed_commands();
      logic [47:0] fs;
      fs = 48'h0012_3456_7890;
      apply_config(make_config(48'hFFFF_FFFF_FFFF, 4'd9, 1'b1, 4'hF, fs, 32'd16));
      send_command(make_cmd(OP_READ_DMA, 48'd0, 16'd8, FEAT_UNUSED, 32'd4096));
      send_command(make_cmd(OP_WRITE_DMA_EXT, 48'h100, 16'd1, FEAT_UNUSED, 32'd512));
      send_command(make_cmd(OP_READ_DMA_EXT, fs, 16'd4, FEAT_UNUSED, 32'hFFFF_FFFF));
      send_command(make_cmd(OP_WRITE_DMA, fs + 48'd15, 16'd2, FEAT_UNUSED, 32'hFFFF_FFFF));
      send_command(make_cmd(OP_VERIFY, fs - 48'd3, 16'd4, FEAT_UNUSED, 32'd0));
      send_command(make_cmd(OP_VERIFY_EXT, fs + 48'd8, 16'd1, FEAT_UNUSED, 32'd0));
      // zero count passes every check and moves nothing
      send_command(make_cmd(OP_READ_DMA, 48'd5, 16'd0, FEAT_UNUSED, 32'd0));
      send_command(make_cmd(OP_WRITE_DMA, 48'd0, 16'd16, FEAT_UNUSED, 32'd8191));
      send_command(make_cmd(OP_READ_DMA_EXT, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF,
                            32'hFFFF_FFFF));
      send_command(make_cmd(OP_SET_FEATURES, 48'd0, {8'h00, MODE_GRP_PIO, 4'hC},
                            FEAT_XFER_MODE, 32'd0));
      send_command(make_cmd(OP_SET_FEATURES, 48'd0, {8'h00, MODE_GRP_PIO, 4'h4},
                            FEAT_XFER_MODE, 32'd0));
      send_command(make_cmd(OP_SET_FEATURES, 48'd0, {8'h00, MODE_GRP_MWDMA, 4'h2},
                            FEAT_XFER_MODE, 32'd0));
      send_command(make_cmd(OP_SET_FEATURES, 48'd0, {8'h00, MODE_GRP_UDMA, 4'h5},
                            FEAT_XFER_MODE, 32'd0));
      send_command(make_cmd(OP_SET_FEATURES, 48'd0, {8'h00, MODE_GRP_BAD, 4'hA},
                            FEAT_XFER_MODE, 32'd0));
      send_command(make_cmd(OP_SET_FEATURES, 48'd0, 16'd0, FEAT_WCACHE_OFF, 32'd0));
      send_command(make_cmd(OP_SET_FEATURES, 48'd0, 16'd0, FEAT_WCACHE_ON, 32'd0));
      send_command(make_cmd(OP_SET_FEATURES, 48'd0, 16'd0, FEAT_UNUSED, 32'd0));
      send_command(make_cmd(OP_SET_MULT, 48'd0, 16'd0, FEAT_UNUSED, 32'd0));
      send_command(make_cmd(OP_CHECK_POWER, 48'd0, 16'd0, FEAT_UNUSED, 32'd0));
      send_command(make_cmd(OP_STANDBY, 48'd0, 16'd0, FEAT_UNUSED, 32'd0));
      send_command(make_cmd(OP_IDENTIFY, 48'd0, 16'd0, FEAT_UNUSED, 32'd0));
      send_command(make_cmd(OP_PIDENTIFY, 48'd0, 16'd0, FEAT_UNUSED, 32'd0));
      send_command(make_cmd(OP_FLUSH, 48'd0, 16'd0, FEAT_UNUSED, 32'd0));
      send_command(make_cmd(OP_FLUSH_EXT, 48'd0, 16'd0, FEAT_UNUSED, 32'd0));
      send_command(make_cmd(OP_UNUSED, 48'd0, 16'd0, OP_UNUSED, 32'd0));
   endtask

   // 28-bit addressing: EXT transfers abort, head byte supplies address bits 31..24
   task automatic test_legacy_addressing();
      ata_cmd_type c;
      apply_config(make_config(48'h0000_FFFF_FFFF, 4'd12, 1'b0, 4'h2, 48'd0, 32'd0));
      send_command(make_cmd(OP_READ_DMA_EXT, 48'h10, 16'd1, FEAT_UNUSED, 32'hFFFF_FFFF));
      send_command(make_cmd(OP_WRITE_DMA_EXT, 48'h10, 16'd1, FEAT_UNUSED, 32'hFFFF_FFFF));
      send_command(make_cmd(OP_VERIFY_EXT, 48'h20, 16'd1, FEAT_UNUSED, 32'd0));
      // zero-length window at sector zero covers every range
      c = make_cmd(OP_READ_DMA, 48'hFF00_0010, 16'd2, FEAT_UNUSED, 32'd8192);
      send_command(c);
      c = make_cmd(OP_WRITE_DMA, 48'hFF00_0010, 16'h7701, FEAT_UNUSED, 32'd4096);
      c.lba_prev = 24'hABCDEF;
      send_command(c);
   endtask

   task automatic test_random_settings();
      apply_config(make_config(48'h0100_0000_0000, 4'd9, 1'b1, 4'hF,
                               {16'd0, $urandom}, 32'($urandom_range(1, 64))));
      run_random_commands(200);
      apply_config(make_config(48'hFFFF_FFFF_FFFF, 4'd15, 1'b1, 4'h6,
                               48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
      run_random_commands(200);
      apply_config(make_config(48'd0, 4'd0, 1'b0, 4'h9, 48'd0, 32'd0));
      run_random_commands(200);
      apply_config(make_config(48'h0001_0000_0000, 4'd12, 1'b0, 4'hA,
                               {16'd0, $urandom}, 32'($urandom_range(0, 4096))));
      run_random_commands(200);
      apply_config(make_config({16'($urandom), $urandom}, 4'($urandom), 1'($urandom),
                               4'($urandom), {16'($urandom), $urandom}, $urandom));
      run_random_commands(200);
      apply_config(make_config(48'h0000_1000_0000, 4'd9, 1'b1, 4'h1,
                               48'h0000_0FFF_FF00, 32'h0000_0200));
      run_random_commands(200);
   endtask

   task automatic test_full_rate();
      apply_config(make_config(48'h0000_8000_0000, 4'd4, 1'b1, 4'h0, 48'h100, 32'd100));
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      run_random_commands(150);
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // hold results long enough that the pipeline fills and stalls requests
   task automatic test_result_backpressure();
      apply_config(make_config(48'h0000_0100_0000, 4'd9, 1'b1, 4'hF,
                               48'h0000_0000_0400, 32'd64));
      hold_request = 80;
      run_random_commands(40);
   endtask

   task automatic test_drain_pause();
      run_random_commands(30);
      drain_outcomes();
      run_random_commands(30);
   endtask

   initial begin
      reset              <= 1'b1;
      csr_write_en       <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_valid          <= 1'b0;
      req_command_code   <= '0;
      req_lba_current    <= '0;
      req_lba_previous   <= '0;
      req_device_head    <= '0;
      req_count_current  <= '0;
      req_count_previous <= '0;
      req_feature_code   <= '0;
      req_buffer_bytes   <= '0;
      disk_cfg     = make_config(48'd0, 4'd9, 1'b1, 4'h0, 48'd0, 32'd0);
      pio_state    = atacc_pkg::PIO_RESET;
      mwdma_state  = atacc_pkg::MWDMA_RESET;
      udma_state   = atacc_pkg::UDMA_RESET;
      wcache_state = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_commands();
      test_legacy_addressing();
      test_random_settings();
      test_full_rate();
      test_result_backpressure();
      test_drain_pause();
      drain_outcomes();

      $display("Checked %0d of %0d commands over %0d register settings.",
               outcomes_seen, cmds_sent, setting_count);
      $display("Covered bound, buffer and fault-window checks, mode and cache updates, %s",
               "idle gaps, full rate and result hold-off.");
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
